[rtl/jps_pkg.sv]
// Shared types, byte codes and sizes for the JSON preflight scanner.
// No dependencies; every other file of the scanner imports this package.
`default_nettype none

package jps_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned DEPTH_W = 9;
	localparam int unsigned CNT_W   = 21;

	localparam logic [CNT_W-1:0]  MAX_BYTES      = CNT_W'(1048576);
	localparam logic [CNT_W-1:0]  CNT_MAX        = {CNT_W{1'b1}};
	localparam logic [BYTE_W-1:0] NEST_LIMIT_RST = BYTE_W'(32);

	localparam logic [BYTE_W-1:0] CH_QUOTE   = 8'h22;
	localparam logic [BYTE_W-1:0] CH_BSLASH  = 8'h5C;
	localparam logic [BYTE_W-1:0] CH_LBRACE  = 8'h7B;
	localparam logic [BYTE_W-1:0] CH_RBRACE  = 8'h7D;
	localparam logic [BYTE_W-1:0] CH_LBRACK  = 8'h5B;
	localparam logic [BYTE_W-1:0] CH_RBRACK  = 8'h5D;
	localparam logic [BYTE_W-1:0] CH_COLON   = 8'h3A;
	localparam logic [BYTE_W-1:0] CH_COMMA   = 8'h2C;
	localparam logic [BYTE_W-1:0] CH_DIGIT0  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_DIGIT9  = 8'h39;
	localparam logic [BYTE_W-1:0] CH_CTRL_LT = 8'h20;

	// One byte held in the input stage.
	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data_byte;
		logic              last_byte;
	} byte_slot_t;

	// Per-document scan state.
	typedef struct packed {
		logic [DEPTH_W-1:0] nest_depth;
		logic               inside_string;
		logic               escape_pending;
		logic               awaiting_key;
		logic               colon_seen;
		logic               scan_stopped;
		logic [DEPTH_W-1:0] peak_depth;
		logic [CNT_W-1:0]   string_total;
		logic [CNT_W-1:0]   digit_total;
		logic [CNT_W-1:0]   byte_total;
		logic               flag_malf;
		logic               flag_ctrl;
		logic               flag_depth;
		logic               flag_dup;
	} doc_state_t;

	// Summary payload of one document.
	typedef struct packed {
		logic               status;
		logic               malformed;
		logic               control_char_seen;
		logic               depth_exceeded;
		logic               dup_key_risk;
		logic [DEPTH_W-1:0] deepest_level;
		logic [CNT_W-1:0]   strings_seen;
		logic [CNT_W-1:0]   digits_seen;
	} summary_t;

	// Bytes that may stand outside a string without stopping the scan:
	// C-locale whitespace, minus sign, point and the letters of true/false/null.
	function automatic logic is_allowed_bare(input logic [BYTE_W-1:0] c);
		logic ok;
		ok = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D) || (c == 8'h2D) ||
			(c == 8'h2E) || (c == 8'h74) || (c == 8'h66) || (c == 8'h6E) ||
			(c == 8'h72) || (c == 8'h75) || (c == 8'h65) || (c == 8'h61) ||
			(c == 8'h6C) || (c == 8'h73);
		return ok;
	endfunction

endpackage

`default_nettype wire

[rtl/jps_if.sv]
// Handshake channels of the scanner: document bytes in, summaries out.
// Depends on jps_pkg for field widths.
`default_nettype none

interface jps_byte_if import jps_pkg::*;;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              last_byte;

	modport source (output valid, data_byte, last_byte, input ready);
	modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface jps_summary_if import jps_pkg::*;;
	logic               valid;
	logic               ready;
	logic               status;
	logic               malformed;
	logic               control_char_seen;
	logic               depth_exceeded;
	logic               dup_key_risk;
	logic [DEPTH_W-1:0] deepest_level;
	logic [CNT_W-1:0]   strings_seen;
	logic [CNT_W-1:0]   digits_seen;

	modport source (output valid, status, malformed, control_char_seen, depth_exceeded,
		dup_key_risk, deepest_level, strings_seen, digits_seen, input ready);
	modport sink (input valid, status, malformed, control_char_seen, depth_exceeded,
		dup_key_risk, deepest_level, strings_seen, digits_seen, output ready);
endinterface

`default_nettype wire

[rtl/jps_in_stage.sv]
// Input register of the scanner: captures one byte per cycle from the byte channel unless the scan unit holds its byte.
// Depends on jps_pkg and jps_byte_if.
`default_nettype none

module jps_in_stage import jps_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	jps_byte_if.sink    doc,
	input  wire logic   advance,
	output byte_slot_t  slot
);

	logic              valid_s1;
	logic [BYTE_W-1:0] data_s1;
	logic              last_s1;
	logic              take;

	// The stage frees itself in the same cycle it hands its byte on.
	assign doc.ready = !valid_s1 || advance;
	assign take      = doc.valid && doc.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (doc.ready) begin
			valid_s1 <= doc.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_s1 <= doc.data_byte;
			last_s1 <= doc.last_byte;
		end
	end

	assign slot = '{valid: valid_s1, data_byte: data_s1, last_byte: last_s1};

endmodule

`default_nettype wire

[rtl/jps_scan_unit.sv]
// Scan state, per-byte update logic and the summary output register.
// Depends on jps_pkg and jps_summary_if.
`default_nettype none

module jps_scan_unit import jps_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire byte_slot_t        slot,
	input  wire logic [BYTE_W-1:0] nest_limit,
	output logic                   advance,
	jps_summary_if.source          summary
);

	doc_state_t        cur_q;
	doc_state_t        nxt;
	summary_t          res;
	summary_t          res_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] c;
	logic [DEPTH_W-1:0] depth_inc;
	logic              over;

	assign c         = slot.data_byte;
	assign depth_inc = cur_q.nest_depth + 1'b1;

	// A non-final byte only touches the state; a final byte also needs the
	// output register to be free or emptying this cycle.
	assign advance = slot.valid && (!slot.last_byte || !out_valid_q || summary.ready);

	always_comb begin
		nxt = cur_q;
		if (cur_q.byte_total <= MAX_BYTES) begin
			nxt.byte_total = cur_q.byte_total + 1'b1;
		end
		if (!cur_q.scan_stopped) begin
			if (cur_q.inside_string) begin
				if (cur_q.escape_pending) begin
					nxt.escape_pending = 1'b0;
				end else if (c == CH_BSLASH) begin
					nxt.escape_pending = 1'b1;
				end else if (c == CH_QUOTE) begin
					nxt.inside_string = 1'b0;
					if (cur_q.string_total != CNT_MAX) begin
						nxt.string_total = cur_q.string_total + 1'b1;
					end
					if (cur_q.awaiting_key) begin
						nxt.colon_seen = 1'b1;
					end
				end else if (c < CH_CTRL_LT) begin
					nxt.flag_ctrl = 1'b1;
					nxt.flag_malf = 1'b1;
				end
			end else if (c == CH_QUOTE) begin
				nxt.inside_string = 1'b1;
			end else if (c == CH_LBRACE || c == CH_LBRACK) begin
				nxt.nest_depth = depth_inc;
				if (depth_inc > cur_q.peak_depth) begin
					nxt.peak_depth = depth_inc;
				end
				if (depth_inc > {1'b0, nest_limit}) begin
					nxt.flag_depth   = 1'b1;
					nxt.flag_malf    = 1'b1;
					nxt.scan_stopped = 1'b1;
				end else begin
					nxt.awaiting_key = (c == CH_LBRACE);
					nxt.colon_seen   = 1'b0;
				end
			end else if (c == CH_RBRACE || c == CH_RBRACK) begin
				if (cur_q.nest_depth == '0) begin
					nxt.flag_malf    = 1'b1;
					nxt.scan_stopped = 1'b1;
				end else begin
					nxt.nest_depth   = cur_q.nest_depth - 1'b1;
					nxt.awaiting_key = 1'b0;
					nxt.colon_seen   = 1'b0;
				end
			end else if (c == CH_COLON) begin
				nxt.colon_seen = 1'b1;
			end else if (c == CH_COMMA) begin
				if (cur_q.awaiting_key && !cur_q.colon_seen) begin
					nxt.flag_dup = 1'b1;
				end
				nxt.colon_seen = 1'b0;
			end else if (c >= CH_DIGIT0 && c <= CH_DIGIT9) begin
				if (cur_q.digit_total != CNT_MAX) begin
					nxt.digit_total = cur_q.digit_total + 1'b1;
				end
			end else if (!is_allowed_bare(c)) begin
				nxt.flag_malf    = 1'b1;
				nxt.scan_stopped = 1'b1;
			end
		end
	end

	// Summary as seen after the final byte has been scanned.
	always_comb begin
		over = (nest_limit == '0) || (nxt.byte_total > MAX_BYTES);
		res  = '0;
		if (over) begin
			res.status = 1'b1;
		end else begin
			res.malformed = nxt.flag_malf ||
				(!nxt.scan_stopped && (nxt.inside_string || nxt.nest_depth != '0));
			res.control_char_seen = nxt.flag_ctrl;
			res.depth_exceeded    = nxt.flag_depth;
			res.dup_key_risk      = nxt.flag_dup;
			res.deepest_level     = nxt.peak_depth;
			res.strings_seen      = nxt.string_total;
			res.digits_seen       = nxt.digit_total;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				cur_q <= slot.last_byte ? doc_state_t'('0) : nxt;
			end
			if (advance && slot.last_byte) begin
				out_valid_q <= 1'b1;
			end else if (summary.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && slot.last_byte) begin
			res_q <= res;
		end
	end

	assign summary.valid             = out_valid_q;
	assign summary.status            = res_q.status;
	assign summary.malformed         = res_q.malformed;
	assign summary.control_char_seen = res_q.control_char_seen;
	assign summary.depth_exceeded    = res_q.depth_exceeded;
	assign summary.dup_key_risk      = res_q.dup_key_risk;
	assign summary.deepest_level     = res_q.deepest_level;
	assign summary.strings_seen      = res_q.strings_seen;
	assign summary.digits_seen       = res_q.digits_seen;

endmodule

`default_nettype wire

[rtl/json_preflight_scanner_core.sv]
// Top level of the JSON preflight scanner: depth budget register, input stage
// and scan unit. Depends on jps_pkg, jps_if, jps_in_stage and jps_scan_unit.
`default_nettype none

// Channel   Dir  Handshake     Payload
// doc       in   valid/ready   data_byte[7:0], last_byte
// summary   out  valid/ready   status, malformed, control_char_seen, depth_exceeded,
//                              dup_key_risk, deepest_level[8:0], strings_seen[20:0],
//                              digits_seen[20:0]
// cfg       in   cfg_we        cfg_wdata[7:0] -> depth budget
//
// One byte is accepted every cycle while the scan unit advances. A byte is registered
// on acceptance and scanned from the input register; the summary of a document is
// registered when its final byte is scanned and then shown on the summary channel.
// Reset clears the document state and sets the depth budget to 32.
// Only a final byte waits on a full summary register; other bytes keep
// flowing while a summary is held, so the input stalls only when a second
// summary is ready before the first one has been taken.

module json_preflight_scanner_core import jps_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	jps_byte_if.sink               doc,
	jps_summary_if.source          summary,
	input  wire logic              cfg_we,
	input  wire logic [BYTE_W-1:0] cfg_wdata
);

	logic [BYTE_W-1:0] nest_limit_q;
	byte_slot_t        slot;
	logic              advance;

	// The user must see that the budget is only rewritten while no byte waits in the input
	// register, so the scan unit may read the register directly; the block does not enforce
	// it. A write inside an open document applies to every later opener of that document.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nest_limit_q <= NEST_LIMIT_RST;
		end else if (cfg_we) begin
			nest_limit_q <= cfg_wdata;
		end
	end

	// Input register: holds the byte being scanned.
	jps_in_stage u_in_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.doc     (doc),
		.advance (advance),
		.slot    (slot)
	);

	// Scan state, byte update and summary register.
	jps_scan_unit u_scan_unit (
		.clk        (clk),
		.arst_n     (arst_n),
		.slot       (slot),
		.nest_limit (nest_limit_q),
		.advance    (advance),
		.summary    (summary)
	);

endmodule

`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for json_preflight_scanner_core: directed documents, then random ones.
// Depends on jps_pkg and the jps_byte_if / jps_summary_if channels from the RTL.
`timescale 1ns / 100ps

module tb;
	import jps_pkg::*;

	// A correct run ends well below this limit even if every byte and every summary
	// meets the longest stall.
	localparam int CYCLE_LIMIT = 500_000;
	// Input items for the whole run, directed and random together.
	localparam int ITEM_TARGET = 850;
	// In the directed table this character stands for a NUL byte, which a string cannot hold.
	localparam logic [BYTE_W-1:0] NUL_STANDIN = 8'h7E;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [BYTE_W-1:0] cfg_wdata;

	jps_byte_if doc_ch ();
	jps_summary_if sum_ch ();

	json_preflight_scanner_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.doc(doc_ch),
		.summary(sum_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Mirror of the scanner: the budget register and the state of the open document.
	logic [BYTE_W-1:0] budget_reg;
	logic [DEPTH_W-1:0] doc_depth;
	logic [DEPTH_W-1:0] doc_peak;
	logic in_str;
	logic esc_next;
	logic want_key;
	logic got_colon;
	logic halted;
	logic [CNT_W-1:0] n_strings;
	logic [CNT_W-1:0] n_digits;
	logic [CNT_W-1:0] n_bytes;
	logic f_malf;
	logic f_ctrl;
	logic f_depth;
	logic f_dup;

	// Summaries the scanner still owes us, oldest first.
	summary_t pending_summaries[$];
	// The document that is being built or sent.
	logic [BYTE_W-1:0] doc_bytes[$];

	// One row of the directed table. A row may leave its document open so that the next row
	// continues it under a different budget.
	typedef struct {
		string    text;
		int       budget;
		bit       ends;
		bit       typed;
		summary_t want;
	} doc_row_t;
	doc_row_t doc_rows[$];

	int mismatches = 0;
	int summaries_checked = 0;
	int docs_sent = 0;
	int bytes_fed = 0;
	int cycles = 0;
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost summary ends the run here.
	initial begin
		while (cycles <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timed out after %0d cycles with %0d summaries outstanding.", cycles,
			pending_summaries.size());
		$display("FAIL json_preflight_scanner_core");
		$finish;
	end

	task automatic note_mismatch(input string what, input longint unsigned want,
		input longint unsigned got);
		$display("MISMATCH at %0t ns: %s expected %0d, got %0d", $time, what, want, got);
		mismatches++;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic void clear_document_state();
		doc_depth = '0;
		doc_peak = '0;
		in_str = 1'b0;
		esc_next = 1'b0;
		want_key = 1'b0;
		got_colon = 1'b0;
		halted = 1'b0;
		n_strings = '0;
		n_digits = '0;
		n_bytes = '0;
		f_malf = 1'b0;
		f_ctrl = 1'b0;
		f_depth = 1'b0;
		f_dup = 1'b0;
	endfunction

	function automatic logic bare_ok(input logic [BYTE_W-1:0] c);
		case (c)
			" ", "-", ".", "t", "f", "n", "r", "u", "e", "a", "l", "s": return 1'b1;
			default: return c >= 8'h09 && c <= 8'h0D;
		endcase
	endfunction

	// Advance the mirrored scan by one accepted byte. On the final byte the summary of the
	// document is queued and the state starts over for the next document.
	function automatic void predict_scan(input logic [BYTE_W-1:0] c, input logic is_last);
		summary_t s;
		if (n_bytes <= MAX_BYTES) n_bytes++;
		if (!halted) begin
			if (in_str) begin
				if (esc_next) begin
					esc_next = 1'b0;
				end else if (c == CH_BSLASH) begin
					esc_next = 1'b1;
				end else if (c == CH_QUOTE) begin
					in_str = 1'b0;
					if (n_strings != CNT_MAX) n_strings++;
					// A closed string in an object counts as the key having been seen.
					if (want_key) got_colon = 1'b1;
				end else if (c < CH_CTRL_LT) begin
					f_ctrl = 1'b1;
					f_malf = 1'b1;
				end
			end else if (c == CH_QUOTE) begin
				in_str = 1'b1;
			end else if (c == CH_LBRACE || c == CH_LBRACK) begin
				doc_depth++;
				if (doc_depth > doc_peak) doc_peak = doc_depth;
				// Each opener is held against the budget in force right now.
				if (doc_depth > {1'b0, budget_reg}) begin
					f_depth = 1'b1;
					f_malf = 1'b1;
					halted = 1'b1;
				end else begin
					want_key = (c == CH_LBRACE);
					got_colon = 1'b0;
				end
			end else if (c == CH_RBRACE || c == CH_RBRACK) begin
				if (doc_depth == '0) begin
					f_malf = 1'b1;
					halted = 1'b1;
				end else begin
					doc_depth--;
					want_key = 1'b0;
					got_colon = 1'b0;
				end
			end else if (c == CH_COLON) begin
				got_colon = 1'b1;
			end else if (c == CH_COMMA) begin
				if (want_key && !got_colon) f_dup = 1'b1;
				got_colon = 1'b0;
			end else if (c >= CH_DIGIT0 && c <= CH_DIGIT9) begin
				if (n_digits != CNT_MAX) n_digits++;
			end else if (!bare_ok(c)) begin
				f_malf = 1'b1;
				halted = 1'b1;
			end
		end
		if (is_last) begin
			s = '0;
			if (budget_reg == '0 || n_bytes > MAX_BYTES) begin
				s.status = 1'b1;
			end else begin
				// An open string or open nesting only counts when the scan ran to the end.
				s.malformed = f_malf | (!halted && (in_str || doc_depth != '0));
				s.control_char_seen = f_ctrl;
				s.depth_exceeded = f_depth;
				s.dup_key_risk = f_dup;
				s.deepest_level = doc_peak;
				s.strings_seen = n_strings;
				s.digits_seen = n_digits;
			end
			pending_summaries.push_back(s);
			clear_document_state();
		end
	endfunction

	function automatic summary_t summary_of(input int st, input int malf, input int ctrl,
		input int dep, input int dup, input int unsigned deep, input int unsigned strs,
		input int unsigned digs);
		summary_t s;
		s.status = st[0];
		s.malformed = malf[0];
		s.control_char_seen = ctrl[0];
		s.depth_exceeded = dep[0];
		s.dup_key_risk = dup[0];
		s.deepest_level = DEPTH_W'(deep);
		s.strings_seen = CNT_W'(strs);
		s.digits_seen = CNT_W'(digs);
		return s;
	endfunction

	task automatic add_row(input string text, input int budget, input int ends, input int typed,
		input summary_t want);
		doc_rows.push_back('{text, budget, ends[0], typed[0], want});
	endtask

	// Present one byte at the falling edge, hold it until a rising edge sees ready, then
	// update the mirror at the next falling edge so that it never races the result check.
	task automatic feed_byte(input logic [BYTE_W-1:0] b, input logic is_last);
		int gap;
		gap = 0;
		if (!tx_calm && $urandom_range(0, 99) < 15) gap = pick_gap();
		if (gap > 0) begin
			doc_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		doc_ch.valid = 1'b1;
		doc_ch.data_byte = b;
		doc_ch.last_byte = is_last;
		@(posedge clk);
		while (!doc_ch.ready) @(posedge clk);
		@(negedge clk);
		predict_scan(b, is_last);
		bytes_fed++;
	endtask

	task automatic send_span(input int lo, input int hi, input bit ends);
		for (int i = lo; i <= hi; i++) feed_byte(doc_bytes[i], ends && i == hi);
		if (ends) docs_sent++;
	endtask

	// Wait until every owed summary has arrived and the last byte has left the scan stage.
	task automatic settle_block();
		doc_ch.valid = 1'b0;
		while (pending_summaries.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_budget(input int value);
		settle_block();
		cfg_we = 1'b1;
		cfg_wdata = BYTE_W'(value);
		budget_reg = BYTE_W'(value);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic void put(input logic [BYTE_W-1:0] b);
		doc_bytes.push_back(b);
	endfunction

	function automatic void put_text(input string t);
		for (int i = 0; i < t.len(); i++) put(t[i]);
	endfunction

	// Now and then a whitespace byte, drawn from all six that count as whitespace.
	function automatic void pad();
		int r;
		if ($urandom_range(0, 4) == 0) begin
			r = $urandom_range(0, 5);
			put(r == 0 ? 8'h20 : BYTE_W'(8 + r));
		end
	endfunction

	// A string with mostly printable content, plus escapes, high bytes, control bytes and digits.
	function automatic void put_str();
		int n;
		int r;
		logic [BYTE_W-1:0] c;
		put(CH_QUOTE);
		n = $urandom_range(0, 6);
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 65) begin
				c = BYTE_W'($urandom_range(8'h20, 8'h7E));
				if (c == CH_QUOTE || c == CH_BSLASH) c = "x";
				put(c);
			end else if (r < 78) begin
				put(CH_BSLASH);
				put(BYTE_W'($urandom_range(8'h20, 8'h7E)));
			end else if (r < 88) begin
				put(BYTE_W'($urandom_range(8'h80, 8'hFF)));
			end else if (r < 93) begin
				put(BYTE_W'($urandom_range(8'h00, 8'h1F)));
			end else begin
				put(CH_DIGIT0 + BYTE_W'($urandom_range(0, 9)));
			end
		end
		put(CH_QUOTE);
	endfunction

	function automatic void put_scalar();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4) begin
			if ($urandom_range(0, 2) == 0) put("-");
			repeat ($urandom_range(1, 4)) put(CH_DIGIT0 + BYTE_W'($urandom_range(0, 9)));
			if ($urandom_range(0, 3) == 0) begin
				put(".");
				put(CH_DIGIT0 + BYTE_W'($urandom_range(0, 9)));
			end
			if ($urandom_range(0, 5) == 0) begin
				put("e");
				if ($urandom_range(0, 1) == 1) put("-");
				put(CH_DIGIT0 + BYTE_W'($urandom_range(1, 9)));
			end
		end else if (r == 4) begin
			put_text("true");
		end else if (r == 5) begin
			put_text("false");
		end else if (r == 6) begin
			put_text("null");
		end else begin
			put_str();
		end
	endfunction

	function automatic void put_key();
		put_str();
		pad();
		put(CH_COLON);
		pad();
	endfunction

	// Build a well-formed document as a random walk over values, commas and closers.
	// Most documents stay shallow; a deep one can run past the default budget.
	function automatic void build_json();
		bit nest_obj[$];
		bit want_value;
		bit done;
		bit is_obj;
		bit deep;
		int elems;
		int max_nest;
		int open_odds;
		deep = ($urandom_range(0, 9) == 0);
		max_nest = deep ? $urandom_range(10, 40) : $urandom_range(1, 5);
		elems = deep ? $urandom_range(20, 45) : $urandom_range(1, 12);
		open_odds = deep ? 7 : 4;
		want_value = 1'b1;
		done = 1'b0;
		pad();
		while (!done) begin
			if (want_value) begin
				if ($urandom_range(0, 9) < open_odds && nest_obj.size() < max_nest && elems > 0) begin
					is_obj = 1'($urandom_range(0, 1));
					put(is_obj ? CH_LBRACE : CH_LBRACK);
					pad();
					elems--;
					if ($urandom_range(0, 4) == 0) begin
						put(is_obj ? CH_RBRACE : CH_RBRACK);
						want_value = 1'b0;
					end else begin
						nest_obj.push_back(is_obj);
						if (is_obj) put_key();
					end
				end else begin
					put_scalar();
					want_value = 1'b0;
				end
			end else if (nest_obj.size() == 0) begin
				done = 1'b1;
			end else if (elems > 0 && $urandom_range(0, 2) != 0) begin
				elems--;
				put(CH_COMMA);
				pad();
				if (nest_obj[nest_obj.size() - 1]) put_key();
				want_value = 1'b1;
			end else begin
				put(nest_obj[nest_obj.size() - 1] ? CH_RBRACE : CH_RBRACK);
				void'(nest_obj.pop_back());
				pad();
			end
		end
	endfunction

	// Fill doc_bytes with one random document: mostly well-formed, some damaged, some noise.
	function automatic void make_doc();
		int r;
		int cut;
		doc_bytes.delete();
		r = $urandom_range(0, 99);
		if (r < 65) begin
			build_json();
		end else if (r < 82) begin
			build_json();
			case ($urandom_range(0, 2))
				0: doc_bytes[$urandom_range(0, doc_bytes.size() - 1)] =
					BYTE_W'($urandom_range(0, 255));
				1: begin
					if (doc_bytes.size() > 1) begin
						cut = $urandom_range(1, doc_bytes.size() - 1);
						while (doc_bytes.size() > cut) void'(doc_bytes.pop_back());
					end
				end
				default: doc_bytes.push_front($urandom_range(0, 1) == 1 ? CH_RBRACE : CH_RBRACK);
			endcase
		end else begin
			repeat ($urandom_range(1, 12)) put(BYTE_W'($urandom_range(0, 255)));
		end
	endfunction

	// Result side: stalls of random length, with calm stretches where ready stays high.
	initial begin
		int hold;
		int mode_left;
		hold = 0;
		mode_left = 0;
		sum_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				sum_ch.ready = 1'b0;
				hold--;
			end else begin
				sum_ch.ready = 1'b1;
				if (!rx_calm && $urandom_range(0, 99) < 25) hold = pick_gap();
			end
			if (mode_left == 0) begin
				rx_calm = ($urandom_range(0, 3) == 0);
				mode_left = $urandom_range(50, 300);
			end else begin
				mode_left--;
			end
		end
	end

	// Every accepted summary is held against the oldest owed one, field by field.
	always @(posedge clk) begin
		summary_t got;
		summary_t want;
		if (arst_n && sum_ch.valid && sum_ch.ready) begin
			got.status = sum_ch.status;
			got.malformed = sum_ch.malformed;
			got.control_char_seen = sum_ch.control_char_seen;
			got.depth_exceeded = sum_ch.depth_exceeded;
			got.dup_key_risk = sum_ch.dup_key_risk;
			got.deepest_level = sum_ch.deepest_level;
			got.strings_seen = sum_ch.strings_seen;
			got.digits_seen = sum_ch.digits_seen;
			if (pending_summaries.size() == 0) begin
				note_mismatch("summary count (none owed)", 0, 1);
			end else begin
				want = pending_summaries.pop_front();
				summaries_checked++;
				if (got.status !== want.status)
					note_mismatch("status", want.status, got.status);
				if (got.malformed !== want.malformed)
					note_mismatch("malformed", want.malformed, got.malformed);
				if (got.control_char_seen !== want.control_char_seen)
					note_mismatch("control_char_seen", want.control_char_seen,
						got.control_char_seen);
				if (got.depth_exceeded !== want.depth_exceeded)
					note_mismatch("depth_exceeded", want.depth_exceeded, got.depth_exceeded);
				if (got.dup_key_risk !== want.dup_key_risk)
					note_mismatch("dup_key_risk", want.dup_key_risk, got.dup_key_risk);
				if (got.deepest_level !== want.deepest_level)
					note_mismatch("deepest_level", want.deepest_level, got.deepest_level);
				if (got.strings_seen !== want.strings_seen)
					note_mismatch("strings_seen", want.strings_seen, got.strings_seen);
				if (got.digits_seen !== want.digits_seen)
					note_mismatch("digits_seen", want.digits_seen, got.digits_seen);
			end
		end
	end

	initial begin
		string open255;
		int carry_from;
		int docs_in_phase;
		int rand_docs;
		int r;
		int b;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		doc_ch.valid = 1'b0;
		doc_ch.data_byte = '0;
		doc_ch.last_byte = 1'b0;
		budget_reg = NEST_LIMIT_RST;
		clear_document_state();
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		open255 = "";
		for (int i = 0; i < 255; i++) begin
			open255 = {open255, "["};
		end

		// Directed table. Rows whose summary is obvious carry it typed in; the rest go
		// through the mirror. The first row runs with the budget left by reset.
		add_row("{\"a\":[1,2,3]}", -1, 1, 1, summary_of(0, 0, 0, 0, 0, 2, 1, 3));
		add_row("[]", -1, 1, 1, summary_of(0, 0, 0, 0, 0, 1, 0, 0));
		// A closer at depth zero stops the scan; so does any byte not allowed bare.
		add_row("}", -1, 1, 1, summary_of(0, 1, 0, 0, 0, 0, 0, 0));
		add_row("]]1", -1, 1, 1, summary_of(0, 1, 0, 0, 0, 0, 0, 0));
		add_row("@[1]", -1, 1, 1, summary_of(0, 1, 0, 0, 0, 0, 0, 0));
		add_row("\377", -1, 1, 1, summary_of(0, 1, 0, 0, 0, 0, 0, 0));
		add_row("~", -1, 1, 1, summary_of(0, 1, 0, 0, 0, 0, 0, 0));
		// Open string and open nesting at the final byte.
		add_row("\"abc", -1, 1, 1, summary_of(0, 1, 0, 0, 0, 0, 0, 0));
		add_row("[1,", -1, 1, 0, '0);
		// Control bytes inside a string, a tab and a NUL, then a high byte.
		add_row("\"a\tb\"", -1, 1, 1, summary_of(0, 1, 1, 0, 0, 0, 1, 0));
		add_row("\"~\"", -1, 1, 1, summary_of(0, 1, 1, 0, 0, 0, 1, 0));
		add_row("\"\377\"", -1, 1, 0, '0);
		// A comma inside an object before any key.
		add_row("{1,2}", -1, 1, 1, summary_of(0, 0, 0, 0, 1, 1, 0, 2));
		add_row("{\"k\":1,\"j\":[2,{}]}", -1, 1, 0, '0);
		add_row("\"x\\\"y\\\\\"", -1, 1, 0, '0);
		add_row(" \t\n\013\014\015[true, false, null, -1.5e3]\015\n", -1, 1, 0, '0);
		add_row("7", -1, 1, 0, '0);
		// A zero budget makes every document out of budget.
		add_row("{}", 0, 1, 1, summary_of(1, 0, 0, 0, 0, 0, 0, 0));
		add_row("[[1]]", 1, 1, 1, summary_of(0, 1, 0, 1, 0, 2, 0, 0));
		// The widest budget: full depth keeps the scan running, so the open nesting is
		// what marks it malformed; one more level stops the scan on depth.
		add_row(open255, 255, 1, 1, summary_of(0, 1, 0, 0, 0, 255, 0, 0));
		add_row({open255, "["}, -1, 1, 1, summary_of(0, 1, 0, 1, 0, 256, 0, 0));
		// The budget drops while a document is open; the next opener sees the new value.
		add_row("[[[", 4, 0, 0, '0);
		add_row("[]]]", 2, 1, 0, '0);
		add_row("[1]", 32, 1, 0, '0);

		foreach (doc_rows[i]) begin
			tx_calm = ($urandom_range(0, 3) == 0);
			if (doc_rows[i].budget >= 0) set_budget(doc_rows[i].budget);
			doc_bytes.delete();
			for (int j = 0; j < doc_rows[i].text.len(); j++)
				put(doc_rows[i].text[j] == NUL_STANDIN ? 8'h00 : doc_rows[i].text[j]);
			send_span(0, doc_bytes.size() - 1, doc_rows[i].ends);
			if (doc_rows[i].typed)
				pending_summaries[pending_summaries.size() - 1] = doc_rows[i].want;
		end

		// Random part in phases, each under a budget of its own. The last document of a
		// phase is sometimes cut, and its tail is sent after the next budget write.
		rand_docs = 0;
		carry_from = -1;
		while (bytes_fed < ITEM_TARGET || rand_docs < 8) begin
			r = $urandom_range(0, 9);
			if (r == 0) b = 0;
			else if (r == 1) b = 255;
			else if (r == 2) b = 1;
			else if (r < 6) b = $urandom_range(2, 6);
			else if (r < 8) b = 32;
			else b = $urandom_range(7, 40);
			set_budget(b);
			if (carry_from >= 0) begin
				send_span(carry_from, doc_bytes.size() - 1, 1'b1);
				rand_docs++;
				carry_from = -1;
			end
			docs_in_phase = (b == 0) ? 2 : $urandom_range(2, 5);
			for (int d = 0; d < docs_in_phase; d++) begin
				tx_calm = ($urandom_range(0, 3) == 0);
				make_doc();
				if (d == docs_in_phase - 1 && doc_bytes.size() > 1 && $urandom_range(0, 3) == 0) begin
					carry_from = $urandom_range(1, doc_bytes.size() - 1);
					send_span(0, carry_from - 1, 1'b0);
				end else begin
					send_span(0, doc_bytes.size() - 1, 1'b1);
					rand_docs++;
				end
			end
		end
		if (carry_from >= 0) send_span(carry_from, doc_bytes.size() - 1, 1'b1);

		settle_block();
		$display("Sent %0d documents in %0d bytes; %0d summaries compared, %0d mismatches.",
			docs_sent, bytes_fed, summaries_checked, mismatches);
		$display("Budgets from 0 to 255 were used, with a change inside an open document.");
		if (mismatches == 0) begin
			$display("PASS json_preflight_scanner_core");
		end else begin
			$display("FAIL json_preflight_scanner_core");
		end
		$finish;
	end

endmodule
